/* hdl/frame_dedupe_hash_ring_macros.svh */
// Assertion macros for the frame_dedupe_hash_ring block.
// Depends on nothing; define ASSERT_OFF to compile the assertions out.
`ifndef FRAME_DEDUPE_HASH_RING_MACROS_SVH
`define FRAME_DEDUPE_HASH_RING_MACROS_SVH

`ifndef ASSERT_OFF
`define FDHR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FDHR_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FDHR_ASSERT(lbl, clk, rstn, prop, msg)
`define FDHR_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* hdl/fdhr_pkg.sv */
// Package for the frame_dedupe_hash_ring block: CRC-32 constants and step function,
// and the command and status structs between controller and datapath. No dependencies.
package fdhr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic byte_en;
    logic frame_end;
    logic rd_en;
    logic take_hit;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
  } status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/fdhr_dpath.sv */
// Datapath of the frame_dedupe_hash_ring block: running CRC, hash ring memory,
// scan pointer, fill count, write position and packet counter. Uses fdhr_pkg.
module fdhr_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fdhr_pkg::cmd_t    cmd_i,
  output fdhr_pkg::status_t status_o,
  input  logic [7:0]       data_byte_i,
  output logic             is_duplicate_o,
  output logic [31:0]      packet_number_o,
  output logic [31:0]      frame_hash_o
);
  import fdhr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0]   mem [TABLE_DEPTH];
  logic [63:0]   rdata_q;
  logic          rd_vld_q;
  logic [31:0]   crc_q, crc_d;
  logic [31:0]   hash_q;
  logic [CW-1:0] scan_idx_q;
  logic [CW-1:0] fill_q;
  logic [AW-1:0] wpos_q;
  logic [31:0]   next_num_q;
  logic          dup_q;
  logic [31:0]   num_q;

  assign crc_d = crc_byte(crc_q, data_byte_i);

  assign status_o.more = (scan_idx_q < fill_q);
  assign status_o.hit  = rd_vld_q && (rdata_q[31:0] == hash_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      mem[wpos_q] <= {next_num_q, hash_q};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[scan_idx_q[AW-1:0]];
    end
    if (cmd_i.byte_en && cmd_i.frame_end) begin
      hash_q <= ~crc_d;
    end
    if (cmd_i.take_hit) begin
      dup_q <= 1'b1;
      num_q <= rdata_q[63:32];
    end else if (cmd_i.insert) begin
      dup_q <= 1'b0;
      num_q <= next_num_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      rd_vld_q   <= 1'b0;
      scan_idx_q <= '0;
      fill_q     <= '0;
      wpos_q     <= '0;
      next_num_q <= 32'd1;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.byte_en) begin
        crc_q <= cmd_i.frame_end ? CRC_INIT : crc_d;
      end
      if (cmd_i.byte_en && cmd_i.frame_end) begin
        scan_idx_q <= '0;
      end else if (cmd_i.rd_en) begin
        scan_idx_q <= scan_idx_q + CW'(1);
      end
      if (cmd_i.insert) begin
        next_num_q <= next_num_q + 32'd1;
        wpos_q     <= (wpos_q == AW'(TABLE_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
        if (fill_q != CW'(TABLE_DEPTH)) begin
          fill_q <= fill_q + CW'(1);
        end
      end
    end
  end

  assign is_duplicate_o  = dup_q;
  assign packet_number_o = num_q;
  assign frame_hash_o    = hash_q;

endmodule

/* hdl/fdhr_ctrl.sv */
// Controller of the frame_dedupe_hash_ring block: takes beats, runs the ring scan
// and decides hit or insert. Uses fdhr_pkg for the command and status structs.
module fdhr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_byte_i,
  input  fdhr_pkg::status_t status_i,
  output fdhr_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import fdhr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_en   = accept;
    cmd_o.frame_end = accept && last_byte_i;
    if (state_q == ST_SCAN) begin
      priority if (status_i.hit) begin
        cmd_o.take_hit = 1'b1;
      end else if (!status_i.more) begin
        cmd_o.insert = 1'b1;
      end else begin
        cmd_o.rd_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_byte_i) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status_i.hit || !status_i.more) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q == ST_SCAN);
  assign done_o = done_q;

endmodule

/* hdl/frame_dedupe_hash_ring.sv */
// Top level of the frame_dedupe_hash_ring block: CRC-32 duplicate frame filter.
// Instantiates fdhr_ctrl and fdhr_dpath; uses fdhr_pkg and the assertion macros.
//
//   channel   handshake        payload
//   input     start_i, busy_o  data_byte_i, last_byte_i
//   result    done_o           is_duplicate_o, packet_number_o, frame_hash_o
//
// A byte that is not the last of its frame does not raise busy_o.
// The last byte starts a scan of the hash ring, one entry a cycle through the memory
// read port, over the entries filled so far (at most TABLE_DEPTH): busy_o stays high
// until a hit or the last filled entry is checked; the result beat follows.
// Reset leaves the ring empty; a fill count marks the valid entries.
// The result beat lasts one cycle and the receiver cannot stall it.
`include "frame_dedupe_hash_ring_macros.svh"

module frame_dedupe_hash_ring #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        done_o,
  output logic        is_duplicate_o,
  output logic [31:0] packet_number_o,
  output logic [31:0] frame_hash_o
);
  import fdhr_pkg::*;

  cmd_t    cmd;
  status_t status;

  fdhr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_byte_i (last_byte_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  fdhr_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (data_byte_i),
    .is_duplicate_o  (is_duplicate_o),
    .packet_number_o (packet_number_o),
    .frame_hash_o    (frame_hash_o)
  );

  `FDHR_ASSERT(a_done_after_busy, clk_i, rst_ni, done_o |-> $past(busy_o), "result beat without a scan")
  `FDHR_ASSERT(a_last_starts_scan, clk_i, rst_ni, (start_i && !busy_o && last_byte_i) |=> busy_o, "last byte did not start a scan")
  `FDHR_ASSERT(a_done_frees, clk_i, rst_ni, done_o |-> !busy_o, "busy during result beat")
  `FDHR_ASSERT_NEVER(a_no_double_done, clk_i, rst_ni, done_o && $past(done_o), "two result beats in a row")

endmodule
